// ===== rtl/rws_pkg.sv =====
// Shared constants, payload types and command codes of the roulette wheel selector.
package rws_pkg;

  localparam int unsigned MAX_MEMBERS_DEF = 256;
  localparam int unsigned WALK_LIMIT      = 256;

  localparam int unsigned POP_W = 9;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned FIT_W = 16;
  localparam int unsigned TOT_W = 24;
  localparam int unsigned FRC_W = 16;
  localparam int unsigned PRD_W = FRC_W + TOT_W;

  localparam logic [POP_W-1:0] POP_RESET = 9'd16;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SELECT = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             command;
    logic [IDX_W-1:0] member_index;
    logic [FIT_W-1:0] fitness_value;
    logic [FRC_W-1:0] random_fraction;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] selected_index;
    logic [TOT_W-1:0] fitness_total;
    logic             index_rejected;
  } rsp_t;

  typedef logic [POP_W-1:0] cfg_t;

endpackage

// ===== rtl/rws_if.sv =====
// Valid/ready channel interfaces for the request, response and configuration ports.
interface rws_req_if;
  logic          valid;
  logic          ready;
  rws_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rws_rsp_if;
  logic          valid;
  logic          ready;
  rws_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rws_cfg_if;
  logic          valid;
  logic          ready;
  rws_pkg::cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/roulette_wheel_selector_unit.sv =====
// Roulette wheel selector: fitness store, running total and cumulative-sum walk.
//
//  port    | dir | payload                                              | transaction
//  --------+-----+------------------------------------------------------+--------------------
//  cfg_i   | in  | population_size                                      | valid & ready
//  req_i   | in  | command, member_index, fitness_value, random_fraction| valid & ready
//  rsp_o   | out | selected_index, fitness_total, index_rejected        | valid & ready
//
// One request is worked at a time. A write reads the old entry, updates the total and
// writes it back, then hands over; a rejected write or a select over an empty population
// goes straight to the hand-over. A select walks k members (1 up to the effective
// population size) before it hands over: the single read port of the fitness memory
// delivers one member per cycle.
// Reset clears the total and a valid bit per memory entry; an entry never written reads
// as zero, so no clearing pass is needed. A stalled response waits in the output
// register while the next request is already accepted and worked.
module roulette_wheel_selector_unit #(
  parameter int unsigned MAX_MEMBERS = rws_pkg::MAX_MEMBERS_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  rws_cfg_if.sink      cfg_i,
  rws_req_if.sink      req_i,
  rws_rsp_if.source    rsp_o
);

  // Only members below the walk limit can ever be addressed, so cap the memory there.
  localparam int unsigned DEPTH = (MAX_MEMBERS < rws_pkg::WALK_LIMIT) ?
                                  MAX_MEMBERS : rws_pkg::WALK_LIMIT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = rws_pkg::POP_W;
  localparam int unsigned IW    = rws_pkg::IDX_W;
  localparam int unsigned FW    = rws_pkg::FIT_W;
  localparam int unsigned TW    = rws_pkg::TOT_W;
  localparam int unsigned QW    = rws_pkg::PRD_W;
  localparam int unsigned FRW   = rws_pkg::FRC_W;
  localparam logic [PW-1:0] DEPTH_CAP = DEPTH[PW-1:0];

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // Config writes are taken at once; the user must send them only while idle, unchecked.
  logic [PW-1:0] pop_q;
  logic [PW-1:0] eff_size;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q <= rws_pkg::POP_RESET;
    end else if (cfg_i.valid) begin
      pop_q <= cfg_i.payload;
    end
  end

  // Effective population: register value capped at the memory depth.
  assign eff_size = (pop_q > DEPTH_CAP) ? DEPTH_CAP : pop_q;

  // Control and datapath registers.
  logic [1:0]    state_q,  state_d;
  logic [AW-1:0] cnt_q,    cnt_d;
  logic [TW-1:0] sum_q,    sum_d;
  logic [TW-1:0] slice_q,  slice_d;
  logic [TW-1:0] total_q,  total_d;
  logic [AW-1:0] addr_q,   addr_d;
  logic [FW-1:0] fit_q,    fit_d;
  rws_pkg::rsp_t res_q,    res_d;

  // Fitness memory: one write port, one registered read port.
  logic [FW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic             mem_re;
  logic             mem_we;
  logic [AW-1:0]    rd_addr;
  logic [FW-1:0]    rd_data_q;
  logic             rd_vld_q;
  logic [FW-1:0]    rd_word;

  logic          req_fire;
  logic          fin_load;
  logic [QW-1:0] product;
  logic [TW-1:0] sum_next;
  logic [PW-1:0] cnt_ext;
  logic          last_member;
  logic          rsp_valid_q;
  rws_pkg::rsp_t rsp_data_q;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // An entry never written since reset reads as zero.
  assign rd_word     = rd_vld_q ? rd_data_q : '0;
  assign sum_next    = sum_q + TW'(rd_word);
  assign cnt_ext     = PW'(cnt_q);
  assign last_member = ((cnt_ext + PW'(1)) == eff_size);
  assign product     = QW'(req_i.payload.random_fraction) * QW'(total_q);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    slice_d  = slice_q;
    total_d  = total_q;
    addr_d   = addr_q;
    fit_d    = fit_q;
    res_d    = res_q;
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    rd_addr  = cnt_q;
    fin_load = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          res_d.selected_index = '0;
          res_d.fitness_total  = total_q;
          res_d.index_rejected = 1'b0;
          if (req_i.payload.command == rws_pkg::CMD_WRITE) begin
            fit_d  = req_i.payload.fitness_value;
            addr_d = req_i.payload.member_index[AW-1:0];
            if (PW'(req_i.payload.member_index) >= eff_size) begin
              // Outside the population: flag it and leave the store alone.
              res_d.index_rejected = 1'b1;
              state_d              = ST_FIN;
            end else begin
              mem_re  = 1'b1;
              rd_addr = req_i.payload.member_index[AW-1:0];
              state_d = ST_WRITE;
            end
          end else begin
            slice_d = product[QW-1:FRW];
            sum_d   = '0;
            cnt_d   = '0;
            if (eff_size == '0) begin
              state_d = ST_FIN;
            end else begin
              mem_re  = 1'b1;
              rd_addr = '0;
              state_d = ST_WALK;
            end
          end
        end
      end
      ST_WRITE: begin
        // Swap the old entry out of the total and the new one in.
        total_d             = total_q - TW'(rd_word) + TW'(fit_q);
        mem_we              = 1'b1;
        res_d.fitness_total = total_d;
        state_d             = ST_FIN;
      end
      ST_WALK: begin
        sum_d = sum_next;
        if (sum_next >= slice_q) begin
          res_d.selected_index = IW'(cnt_q);
          state_d              = ST_FIN;
        end else if (last_member) begin
          // Slice beyond every participating sum: fall back to member zero.
          state_d = ST_FIN;
        end else begin
          cnt_d   = cnt_q + AW'(1);
          mem_re  = 1'b1;
          rd_addr = cnt_q + AW'(1);
        end
      end
      ST_FIN: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          fin_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (mem_we) begin
        vld_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    sum_q   <= sum_d;
    slice_q <= slice_d;
    addr_q  <= addr_d;
    fit_q   <= fit_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= fit_q;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
  end

  // Output register: hold the response until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (fin_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      rsp_data_q <= res_q;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_data_q;

`ifndef SYNTHESIS
  // The total moves only on the write-back cycle of an accepted write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_WRITE) |=> $stable(total_q))
    else $error("running total changed outside a write-back");

  // The walk never reads past the effective population.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (cnt_ext < eff_size))
    else $error("walk counter beyond population");

  // A response is loaded only when the output register is free or being drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |-> (!rsp_valid_q || rsp_o.ready))
    else $error("pending response overwritten");
`endif

endmodule
